### rtl/generational_slot_lifecycle_table_assert.svh
// ---------------------------------------------------------------------------
// generational slot lifecycle table assertion macros
// shared property forms for the checker files
// ---------------------------------------------------------------------------
`ifndef GENERATIONAL_SLOT_LIFECYCLE_TABLE_ASSERT_SVH
`define GENERATIONAL_SLOT_LIFECYCLE_TABLE_ASSERT_SVH

// same-cycle implication under reset
`define GSLT_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication under reset
`define GSLT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/gslt_pkg.sv
// ---------------------------------------------------------------------------
// gslt_pkg
// codes, defaults and shared types of the slot lifecycle table
// ---------------------------------------------------------------------------
package gslt_pkg;

    // parameter defaults
    localparam int NUM_SLOTS_DEF  = 32;
    localparam int FIRST_SLOT_DEF = 1;
    localparam int GEN_BITS_DEF   = 16;

    // fixed field widths
    localparam int REQ_W   = 3;
    localparam int SLOT_W  = 8;
    localparam int AGEN_W  = 16;
    localparam int TGEN_W  = 16;
    localparam int STAT_W  = 3;
    localparam int LSTATE_W = 3;

    // request types
    localparam logic [REQ_W-1:0] REQ_QUERY   = 3'd0;
    localparam logic [REQ_W-1:0] REQ_RESERVE = 3'd1;
    localparam logic [REQ_W-1:0] REQ_JOIN    = 3'd2;
    localparam logic [REQ_W-1:0] REQ_JOINED  = 3'd3;
    localparam logic [REQ_W-1:0] REQ_REMOVE  = 3'd4;
    localparam logic [REQ_W-1:0] REQ_RELEASE = 3'd5;

    // lifecycle states
    localparam logic [LSTATE_W-1:0] ST_VACANT   = 3'd0;
    localparam logic [LSTATE_W-1:0] ST_RESERVED = 3'd1;
    localparam logic [LSTATE_W-1:0] ST_JOINING  = 3'd2;
    localparam logic [LSTATE_W-1:0] ST_JOINED   = 3'd3;
    localparam logic [LSTATE_W-1:0] ST_REMOVING = 3'd4;

    // result status
    localparam logic [STAT_W-1:0] RES_OK        = 3'd0;
    localparam logic [STAT_W-1:0] RES_BAD_SLOT  = 3'd1;
    localparam logic [STAT_W-1:0] RES_BAD_TOKEN = 3'd2;
    localparam logic [STAT_W-1:0] RES_BUSY      = 3'd3;
    localparam logic [STAT_W-1:0] RES_EXHAUSTED = 3'd4;
    localparam logic [STAT_W-1:0] RES_NOT_FOUND = 3'd5;
    localparam logic [STAT_W-1:0] RES_BAD_STATE = 3'd6;

    // controller to datapath commands
    typedef struct packed {
        logic capture;  // latch request, start entry read
        logic commit;   // evaluate, write back, load result
    } t_dp_cmd;

endpackage

### rtl/gslt_req_if.sv
// ---------------------------------------------------------------------------
// gslt_req_if
// request channel: valid/ready with the request payload
// ---------------------------------------------------------------------------
interface gslt_req_if
    import gslt_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [REQ_W-1:0]  req_type;
    logic [SLOT_W-1:0] slot;
    logic [AGEN_W-1:0] actor_generation;
    logic [SLOT_W-1:0] token_slot;
    logic [TGEN_W-1:0] token_map_gen;
    logic [TGEN_W-1:0] token_round_gen;
    logic [TGEN_W-1:0] token_slot_gen;

    modport source (
        output valid, req_type, slot, actor_generation, token_slot,
               token_map_gen, token_round_gen, token_slot_gen,
        input  ready
    );
    modport sink (
        input  valid, req_type, slot, actor_generation, token_slot,
               token_map_gen, token_round_gen, token_slot_gen,
        output ready
    );
endinterface

### rtl/gslt_rsp_if.sv
// ---------------------------------------------------------------------------
// gslt_rsp_if
// result channel: valid/ready with the result payload
// ---------------------------------------------------------------------------
interface gslt_rsp_if
    import gslt_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [STAT_W-1:0]   status;
    logic [AGEN_W-1:0]   new_actor_generation;
    logic [LSTATE_W-1:0] record_state;
    logic                is_current;
    logic [AGEN_W-1:0]   slot_occupant_generation;

    modport source (
        output valid, status, new_actor_generation, record_state, is_current,
               slot_occupant_generation,
        input  ready
    );
    modport sink (
        input  valid, status, new_actor_generation, record_state, is_current,
               slot_occupant_generation,
        output ready
    );
endinterface

### rtl/gslt_ctrl.sv
// ---------------------------------------------------------------------------
// gslt_ctrl
// request sequencer and result valid tracking
// ---------------------------------------------------------------------------
module gslt_ctrl
    import gslt_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_dp_cmd o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    assign out_free      = !r_out_valid || i_out_ready;
    assign o_in_ready    = (r_state == S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_cmd.capture = (r_state == S_IDLE) && i_in_valid;
    assign o_cmd.commit  = (r_state == S_EXEC) && out_free;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        if (o_cmd.commit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

### rtl/gslt_dpath.sv
// ---------------------------------------------------------------------------
// gslt_dpath
// slot record memory, request checks and result registers
// ---------------------------------------------------------------------------
module gslt_dpath
    import gslt_pkg::*;
#(
    parameter int NUM_SLOTS  = NUM_SLOTS_DEF,
    parameter int FIRST_SLOT = FIRST_SLOT_DEF,
    parameter int GEN_BITS   = GEN_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_dp_cmd             i_cmd,
    input  logic [REQ_W-1:0]    i_req_type,
    input  logic [SLOT_W-1:0]   i_slot,
    input  logic [AGEN_W-1:0]   i_actor_generation,
    input  logic [SLOT_W-1:0]   i_token_slot,
    input  logic [TGEN_W-1:0]   i_token_map_gen,
    input  logic [TGEN_W-1:0]   i_token_round_gen,
    input  logic [TGEN_W-1:0]   i_token_slot_gen,
    output logic [STAT_W-1:0]   o_status,
    output logic [AGEN_W-1:0]   o_new_actor_generation,
    output logic [LSTATE_W-1:0] o_record_state,
    output logic                o_is_current,
    output logic [AGEN_W-1:0]   o_slot_occupant_generation
);

    localparam int IW   = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int TOKW = 3 * TGEN_W;
    localparam int EW   = LSTATE_W + GEN_BITS + TOKW;
    localparam logic [SLOT_W:0]   FIRST9  = (SLOT_W + 1)'(FIRST_SLOT);
    localparam logic [SLOT_W:0]   NUM9    = (SLOT_W + 1)'(NUM_SLOTS);
    localparam logic [GEN_BITS-1:0] GEN_MAX = {GEN_BITS{1'b1}};

    // record memory and written flags
    logic [EW-1:0]        r_mem [NUM_SLOTS];
    logic [EW-1:0]        r_rd_data;
    logic [NUM_SLOTS-1:0] r_written;

    // latched request
    logic [REQ_W-1:0]  r_req_type;
    logic [SLOT_W-1:0] r_slot;
    logic [AGEN_W-1:0] r_agen;
    logic [SLOT_W-1:0] r_tslot;
    logic [TOKW-1:0]   r_tok;

    // result registers
    logic [STAT_W-1:0]   r_status;
    logic [AGEN_W-1:0]   r_new_gen;
    logic [LSTATE_W-1:0] r_rec_state;
    logic                r_is_cur;
    logic [AGEN_W-1:0]   r_occ;

    logic [SLOT_W:0]       in_off, off;
    logic [IW-1:0]         rd_idx, idx;
    logic                  slot_ok, tok_ok, entry_live;
    logic [LSTATE_W-1:0]   mem_state, cur_state, ns;
    logic [GEN_BITS-1:0]   mem_cnt, cur_cnt, nc, new_gen;
    logic [TOKW-1:0]       mem_tok;
    logic                  wr, wr_en, post_live, post_match;
    logic [STAT_W-1:0]     res;
    logic [31:0]           actor32, nc32, new_gen32;
    logic [EW-1:0]         wr_data;

    assign in_off = {1'b0, i_slot} - FIRST9;
    assign rd_idx = in_off[IW-1:0];
    assign off    = {1'b0, r_slot} - FIRST9;
    assign idx    = off[IW-1:0];

    assign slot_ok    = ({1'b0, r_slot} >= FIRST9) && (off < NUM9);
    assign entry_live = slot_ok && r_written[idx];
    assign tok_ok     = (r_tslot == r_slot) && (r_tok[TOKW-1 -: TGEN_W] != '0)
                        && (r_tok[TGEN_W +: TGEN_W] != '0) && (r_tok[TGEN_W-1:0] != '0);

    assign mem_state = r_rd_data[EW-1 -: LSTATE_W];
    assign mem_cnt   = r_rd_data[TOKW +: GEN_BITS];
    assign mem_tok   = r_rd_data[TOKW-1:0];
    assign cur_state = entry_live ? mem_state : ST_VACANT;
    assign cur_cnt   = entry_live ? mem_cnt : '0;

    always_comb begin
        ns  = cur_state;
        nc  = cur_cnt;
        wr  = 1'b0;
        res = RES_OK;
        case (r_req_type)
            REQ_RESERVE: begin
                if (!slot_ok) begin
                    res = RES_BAD_SLOT;
                end else if (!tok_ok) begin
                    res = RES_BAD_TOKEN;
                end else if (cur_state != ST_VACANT) begin
                    res = RES_BUSY;
                end else if (cur_cnt == GEN_MAX) begin
                    res = RES_EXHAUSTED;
                end else begin
                    nc = cur_cnt + 1'b1;
                    ns = ST_RESERVED;
                    wr = 1'b1;
                end
            end
            default: begin
                // actor lookup, then the move's source state check
                if (!slot_ok) begin
                    res = RES_BAD_SLOT;
                end else if (cur_state == ST_VACANT || 32'(cur_cnt) != 32'(r_agen)) begin
                    res = RES_NOT_FOUND;
                end else begin
                    case (r_req_type)
                        REQ_JOIN: begin
                            if (cur_state == ST_RESERVED) begin
                                ns = ST_JOINING;
                                wr = 1'b1;
                            end else begin
                                res = RES_BAD_STATE;
                            end
                        end
                        REQ_JOINED: begin
                            if (cur_state == ST_JOINING) begin
                                ns = ST_JOINED;
                                wr = 1'b1;
                            end else begin
                                res = RES_BAD_STATE;
                            end
                        end
                        REQ_REMOVE: begin
                            if (cur_state == ST_JOINING || cur_state == ST_JOINED) begin
                                ns = ST_REMOVING;
                                wr = 1'b1;
                            end else begin
                                res = RES_BAD_STATE;
                            end
                        end
                        REQ_RELEASE: begin
                            if (cur_state == ST_RESERVED || cur_state == ST_JOINING
                                || cur_state == ST_REMOVING) begin
                                ns = ST_VACANT;
                                wr = 1'b1;
                            end else begin
                                res = RES_BAD_STATE;
                            end
                        end
                        default: begin
                            // query and unused codes change nothing
                        end
                    endcase
                end
            end
        endcase
    end

    // reported view after the step
    assign new_gen    = (r_req_type == REQ_RESERVE && res == RES_OK) ? nc : '0;
    assign new_gen32  = 32'(new_gen);
    assign nc32       = 32'(nc);
    assign actor32    = (r_req_type == REQ_RESERVE) ? new_gen32 : 32'(r_agen);
    assign post_live  = slot_ok && (ns != ST_VACANT);
    assign post_match = post_live && (nc32 == actor32);

    assign wr_en   = i_cmd.commit && wr;
    assign wr_data = {ns, nc, (r_req_type == REQ_RESERVE) ? r_tok : mem_tok};

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_rd_data <= r_mem[rd_idx];
        end
        if (wr_en) begin
            r_mem[idx] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_written <= '0;
        end else if (wr_en) begin
            r_written[idx] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req_type <= i_req_type;
            r_slot     <= i_slot;
            r_agen     <= i_actor_generation;
            r_tslot    <= i_token_slot;
            r_tok      <= {i_token_map_gen, i_token_round_gen, i_token_slot_gen};
        end
        if (i_cmd.commit) begin
            r_status    <= res;
            r_new_gen   <= new_gen32[AGEN_W-1:0];
            r_rec_state <= post_match ? ns : ST_VACANT;
            r_is_cur    <= post_match && (ns == ST_JOINED) && tok_ok && (mem_tok == r_tok);
            r_occ       <= post_live ? nc32[AGEN_W-1:0] : '0;
        end
    end

    assign o_status                   = r_status;
    assign o_new_actor_generation     = r_new_gen;
    assign o_record_state             = r_rec_state;
    assign o_is_current               = r_is_cur;
    assign o_slot_occupant_generation = r_occ;

endmodule

### rtl/generational_slot_lifecycle_table.sv
// ---------------------------------------------------------------------------
// generational slot lifecycle table
// per-slot lifecycle state, generation counter and stored token, with query /
// reserve / join / joined / remove / release requests checked against them
// ---------------------------------------------------------------------------
//  channel  | dir | handshake     | beat contents
//  ---------+-----+---------------+------------------------------------------
//  i_req    | in  | valid / ready | request type, slot, actor gen, token
//  o_rsp    | out | valid / ready | status, new gen, state, current, occupant
//
//  for each request the entry read from the slot memory is registered, then
//  checked, written back and loaded into the result register
//  a new beat is taken while the previous result still waits on o_rsp
//  when the result register is full and not taken, the request holds in its
//  check cycle; i_req ready stays low until it is committed
//  reset clears the per-slot written flags, so every slot reads as vacant
//  with a zero counter at once; there is no clearing pass
// ---------------------------------------------------------------------------
module generational_slot_lifecycle_table
    import gslt_pkg::*;
#(
    parameter int NUM_SLOTS  = NUM_SLOTS_DEF,   // number of records
    parameter int FIRST_SLOT = FIRST_SLOT_DEF,  // slot number of record zero
    parameter int GEN_BITS   = GEN_BITS_DEF     // generation counter width
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    gslt_req_if.sink   i_req,
    gslt_rsp_if.source o_rsp
);

    // command bundle from sequencer to datapath
    t_dp_cmd cmd;

    gslt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .o_cmd       (cmd)
    );

    // record memory plus checks; all payload lives here
    gslt_dpath #(
        .NUM_SLOTS  (NUM_SLOTS),
        .FIRST_SLOT (FIRST_SLOT),
        .GEN_BITS   (GEN_BITS)
    ) u_dpath (
        .i_clk                      (i_clk),
        .i_rst_n                    (i_rst_n),
        .i_cmd                      (cmd),
        .i_req_type                 (i_req.req_type),
        .i_slot                     (i_req.slot),
        .i_actor_generation         (i_req.actor_generation),
        .i_token_slot               (i_req.token_slot),
        .i_token_map_gen            (i_req.token_map_gen),
        .i_token_round_gen          (i_req.token_round_gen),
        .i_token_slot_gen           (i_req.token_slot_gen),
        .o_status                   (o_rsp.status),
        .o_new_actor_generation     (o_rsp.new_actor_generation),
        .o_record_state             (o_rsp.record_state),
        .o_is_current               (o_rsp.is_current),
        .o_slot_occupant_generation (o_rsp.slot_occupant_generation)
    );

endmodule

### rtl/gslt_checker.sv
// ---------------------------------------------------------------------------
// gslt_checker
// port-level checks of the slot lifecycle table, bound to the top level
// ---------------------------------------------------------------------------
`include "generational_slot_lifecycle_table_assert.svh"

module gslt_checker
    import gslt_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_req_valid,
    input logic                i_req_ready,
    input logic                i_rsp_valid,
    input logic                i_rsp_ready,
    input logic [STAT_W-1:0]   i_status,
    input logic [AGEN_W-1:0]   i_new_gen,
    input logic [LSTATE_W-1:0] i_record_state,
    input logic                i_is_current,
    input logic [AGEN_W-1:0]   i_occupant
);

    // stalled result beat holds
    `GSLT_ASSERT_NEXT(a_rsp_hold, i_clk, i_rst_n, i_rsp_valid && !i_rsp_ready, i_rsp_valid && $stable(i_status) && $stable(i_new_gen) && $stable(i_record_state) && $stable(i_is_current) && $stable(i_occupant), "result beat changed while stalled")

    // one request in flight at a time
    `GSLT_ASSERT_NEXT(a_one_in_flight, i_clk, i_rst_n, i_req_valid && i_req_ready, !i_req_ready, "request taken while previous one in flight")

    // a refused request hands out no generation
    `GSLT_ASSERT_IMPL(a_gen_on_ok, i_clk, i_rst_n, i_rsp_valid && (i_status != RES_OK), i_new_gen == '0, "generation given on refused request")

    // current actor implies joined record
    `GSLT_ASSERT_IMPL(a_cur_joined, i_clk, i_rst_n, i_rsp_valid && i_is_current, i_record_state == ST_JOINED, "current actor on record not joined")

endmodule

bind generational_slot_lifecycle_table gslt_checker u_gslt_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_req_valid    (i_req.valid),
    .i_req_ready    (i_req.ready),
    .i_rsp_valid    (o_rsp.valid),
    .i_rsp_ready    (o_rsp.ready),
    .i_status       (o_rsp.status),
    .i_new_gen      (o_rsp.new_actor_generation),
    .i_record_state (o_rsp.record_state),
    .i_is_current   (o_rsp.is_current),
    .i_occupant     (o_rsp.slot_occupant_generation)
);
